/* sv/pee_pkg.sv */
//==============================================================================
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
//==============================================================================
package pee_pkg;

   localparam int DATA_W          = 32;
   localparam int SYM_W           = 8;
   localparam int STACK_DEPTH_DEF = 64;

   localparam logic [SYM_W-1:0]  SYM_ZERO  = 8'd48;
   localparam logic [SYM_W-1:0]  SYM_PLUS  = 8'd43;
   localparam logic [SYM_W-1:0]  SYM_MINUS = 8'd45;
   localparam logic [SYM_W-1:0]  SYM_STAR  = 8'd42;
   localparam logic [SYM_W-1:0]  SYM_SLASH = 8'd47;
   localparam logic [DATA_W-1:0] NEG_ONE   = '1;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div0;
   } alu_rsp_type;

endpackage

/* sv/pee_req_if.sv */
//==============================================================================
// pee_req_if
// Input channel: one expression character per item.
//==============================================================================
interface pee_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);

endinterface

/* sv/pee_rsp_if.sv */
//==============================================================================
// pee_rsp_if
// Result channel: value of an expression and its error flags.
//==============================================================================
interface pee_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               underflow;
   logic               overflow;
   logic               div_by_zero;

   modport source (output valid, output value, output underflow, output overflow,
                   output div_by_zero, input ready);
   modport sink   (input valid, input value, input underflow, input overflow,
                   input div_by_zero, output ready);

endinterface

/* sv/pee_ram.sv */
//==============================================================================
// pee_ram
// Generic single-write, single-read RAM with registered read data.
//==============================================================================
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pee_alu.sv */
//==============================================================================
// pee_alu
// Shared arithmetic unit: add, subtract and multiply with a registered result,
// signed division truncating toward zero by a restoring divider, one bit per cycle.
//==============================================================================
module pee_alu
   import pee_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_req_type       req,
   input  logic [DATA_W-1:0] lhs,
   input  logic [DATA_W-1:0] rhs,
   output alu_rsp_type       rsp,
   output logic [DATA_W-1:0] result
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic              div0_ff, div0_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvsr_ff, dvsr_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      fix_in  = fix_ff;
      done_in = 1'b0;
      div0_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      res_in  = res_ff;
      if (req.start) begin
         case (req.op)
            OP_ADD: begin
               res_in  = lhs + rhs;
               done_in = 1'b1;
            end
            OP_SUB: begin
               res_in  = lhs - rhs;
               done_in = 1'b1;
            end
            OP_MUL: begin
               res_in  = lhs * rhs;
               done_in = 1'b1;
            end
            OP_DIV: begin
               if (rhs == '0) begin
                  res_in  = '0;
                  div0_in = 1'b1;
                  done_in = 1'b1;
               end else begin
                  // Divide magnitudes; the sign is applied in the fix-up cycle.
                  neg_in  = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                  quo_in  = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
                  dvsr_in = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
                  rem_in  = '0;
                  cnt_in  = '0;
                  busy_in = 1'b1;
               end
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         fix_in  = 1'b0;
         res_in  = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         div0_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         div0_ff <= div0_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.div0 = div0_ff;
   assign result   = res_ff;

endmodule

/* sv/postfix_expression_evaluator.sv */
//==============================================================================
// postfix_expression_evaluator
// Evaluates a postfix expression given one character per item. An operand
// character is pushed as its code minus 48; an operator pops the right and
// the left operand, computes in 32-bit two's complement and pushes the
// result. On the item marked last the top of the stack (or -1 if empty) is
// returned with the sticky underflow, overflow and divide-by-zero flags, and
// the stack is cleared. The stack lives in a RAM of STACK_DEPTH words. The
// block takes one item at a time and is not ready while it works on it: an
// operand is pushed, an operator pops its operands, runs the shared arithmetic
// unit (a division through its bit-serial divider) and pushes the result, and
// the item marked last then reads the top of the stack and waits until the
// output register is free. The result sits in an output register, so the next
// item can be taken while it waits to be accepted.
//==============================================================================
module postfix_expression_evaluator
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   pee_req_if.sink    req_chan,
   pee_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_POP_R = 8'b0000_0010,
      ST_POP_L = 8'b0000_0100,
      ST_EXEC  = 8'b0000_1000,
      ST_WAIT  = 8'b0001_0000,
      ST_PUSH  = 8'b0010_0000,
      ST_TOP   = 8'b0100_0000,
      ST_LOAD  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              last_ff, last_in;
   alu_op_type        op_ff, op_in;
   logic              rhs_ok_ff, rhs_ok_in;
   logic              lhs_ok_ff, lhs_ok_in;
   logic [DATA_W-1:0] rhs_ff, rhs_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              under_ff, under_in;
   logic              over_ff, over_in;
   logic              dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_under_ff, rsp_under_in;
   logic              rsp_over_ff, rsp_over_in;
   logic              rsp_dz_ff, rsp_dz_in;

   logic              wr_en;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [CW-1:0]     count_m1;
   logic              is_op;
   logic              stack_empty;
   logic              stack_full;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic [DATA_W-1:0] alu_lhs;
   logic [DATA_W-1:0] alu_result;

   assign count_m1    = count_ff - CW'(1);
   assign rd_addr     = count_m1[AW-1:0];
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CW'(STACK_DEPTH));
   assign is_op       = (req_chan.symbol == SYM_PLUS) || (req_chan.symbol == SYM_MINUS) ||
                        (req_chan.symbol == SYM_STAR) || (req_chan.symbol == SYM_SLASH);
   assign alu_lhs     = lhs_ok_ff ? rd_data : NEG_ONE;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      rhs_ok_in    = rhs_ok_ff;
      lhs_ok_in    = lhs_ok_ff;
      rhs_in       = rhs_ff;
      val_in       = val_ff;
      under_in     = under_ff;
      over_in      = over_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_under_in = rsp_under_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_dz_in    = rsp_dz_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      alu_req      = '{start: 1'b0, op: op_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               last_in = req_chan.last;
               val_in  = {{(DATA_W - SYM_W){1'b0}}, req_chan.symbol} - DATA_W'(SYM_ZERO);
               case (req_chan.symbol)
                  SYM_PLUS:  op_in = OP_ADD;
                  SYM_MINUS: op_in = OP_SUB;
                  SYM_STAR:  op_in = OP_MUL;
                  default:   op_in = OP_DIV;
               endcase
               state_in = is_op ? ST_POP_R : ST_PUSH;
            end
         end
         ST_POP_R: begin
            rhs_ok_in = !stack_empty;
            if (stack_empty) begin
               under_in = 1'b1;
            end else begin
               rd_en    = 1'b1;
               count_in = count_m1;
            end
            state_in = ST_POP_L;
         end
         ST_POP_L: begin
            rhs_in    = rhs_ok_ff ? rd_data : NEG_ONE;
            lhs_ok_in = !stack_empty;
            if (stack_empty) begin
               under_in = 1'b1;
            end else begin
               rd_en    = 1'b1;
               count_in = count_m1;
            end
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            alu_req.start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (alu_rsp.done) begin
               val_in   = alu_result;
               dz_in    = dz_ff | alu_rsp.div0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (stack_full) begin
               over_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
            state_in = last_ff ? ST_TOP : ST_IDLE;
         end
         ST_TOP: begin
            rd_en    = !stack_empty;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = stack_empty ? NEG_ONE : rd_data;
               rsp_under_in = under_ff | stack_empty;
               rsp_over_in  = over_ff;
               rsp_dz_in    = dz_ff;
               count_in     = '0;
               under_in     = 1'b0;
               over_in      = 1'b0;
               dz_in        = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         dz_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      op_ff        <= op_in;
      rhs_ok_ff    <= rhs_ok_in;
      lhs_ok_ff    <= lhs_ok_in;
      rhs_ff       <= rhs_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_under_ff <= rsp_under_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pee_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .lhs    (alu_lhs),
      .rhs    (rhs_ff),
      .rsp    (alu_rsp),
      .result (alu_result)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value       = rsp_value_ff;
   assign rsp_chan.underflow   = rsp_under_ff;
   assign rsp_chan.overflow    = rsp_over_ff;
   assign rsp_chan.div_by_zero = rsp_dz_ff;

endmodule

/* tb/sv/tb_postfix_expression_evaluator.sv */
`timescale 1ns / 1ps
//==============================================================================
// tb_postfix_expression_evaluator
// Self-checking bench for the postfix expression evaluator. Expression
// characters are sent through the request channel with random gaps. Each
// accepted character is run through a local stack machine that predicts the
// value and flags reported at the end of every expression. The response side
// stalls at random and once holds off long enough to back the block up.
//==============================================================================
module tb_postfix_expression_evaluator;
   import pee_pkg::*;

   localparam int  DEPTH       = STACK_DEPTH_DEF;
   localparam int  HALF_PERIOD = 6;
   localparam int  NUM_CHARS   = 1550;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 64;
   localparam int  HOLD_CYCLES = 1500;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } char_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     underflow;
      logic                     overflow;
      logic                     div_by_zero;
   } outcome_type;

   logic clock;
   logic reset;

   pee_req_if req_if ();
   pee_rsp_if rsp_if ();

   postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // Stimulus and expectations.
   char_item_type  pending_chars[$];
   outcome_type    expected_results[$];

   // Local copy of the evaluator state.
   logic [DATA_W-1:0] stack_mem[DEPTH];
   int                stack_fill;
   logic              sticky_under;
   logic              sticky_over;
   logic              sticky_div0;

   int   error_count;
   int   chars_sent;
   int   results_checked;
   int   under_results;
   int   over_results;
   int   div0_results;
   int   cycle_count;
   int   gap_left;
   int   stall_left;
   logic hold_req;
   char_item_type next_char;

   //---------------------------------------------------------------------------
   // Predictor
   //---------------------------------------------------------------------------
   function automatic logic is_operator(input logic [SYM_W-1:0] sym);
      return sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR || sym == SYM_SLASH;
   endfunction

   function automatic void stack_push(input logic [DATA_W-1:0] v);
      if (stack_fill >= DEPTH) begin
         sticky_over = 1'b1;
      end else begin
         stack_mem[stack_fill] = v;
         stack_fill++;
      end
   endfunction

   function automatic logic [DATA_W-1:0] stack_pop();
      if (stack_fill == 0) begin
         sticky_under = 1'b1;
         return NEG_ONE;
      end
      stack_fill--;
      return stack_mem[stack_fill];
   endfunction

   // Signed division on magnitudes, so the most negative value over -1 wraps.
   function automatic logic [DATA_W-1:0] trunc_div(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] quot;
      if (b == '0) begin
         sticky_div0 = 1'b1;
         return '0;
      end
      mag_a = a[DATA_W-1] ? -a : a;
      mag_b = b[DATA_W-1] ? -b : b;
      quot  = mag_a / mag_b;
      return (a[DATA_W-1] != b[DATA_W-1]) ? -quot : quot;
   endfunction

   task automatic evaluate_symbol(input logic [SYM_W-1:0] sym, input logic lst);
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] res;
      outcome_type       o;
      if (is_operator(sym)) begin
         rhs = stack_pop();
         lhs = stack_pop();
         case (sym)
            SYM_PLUS:  res = lhs + rhs;
            SYM_MINUS: res = lhs - rhs;
            SYM_STAR:  res = lhs * rhs;
            default:   res = trunc_div(lhs, rhs);
         endcase
         stack_push(res);
      end else begin
         stack_push({{(DATA_W-SYM_W){1'b0}}, sym} - {{(DATA_W-SYM_W){1'b0}}, SYM_ZERO});
      end
      if (lst) begin
         if (stack_fill == 0) begin
            sticky_under = 1'b1;
            o.value = NEG_ONE;
         end else begin
            o.value = stack_mem[stack_fill-1];
         end
         o.underflow   = sticky_under;
         o.overflow    = sticky_over;
         o.div_by_zero = sticky_div0;
         expected_results.push_back(o);
         under_results += sticky_under;
         over_results  += sticky_over;
         div0_results  += sticky_div0;
         stack_fill   = 0;
         sticky_under = 1'b0;
         sticky_over  = 1'b0;
         sticky_div0  = 1'b0;
      end
   endtask

   //---------------------------------------------------------------------------
   // Stimulus construction
   //---------------------------------------------------------------------------
   task automatic add_char(input logic [SYM_W-1:0] sym, input logic lst);
      char_item_type c;
      c.symbol = sym;
      c.last   = lst;
      pending_chars.push_back(c);
   endtask

   function automatic logic [SYM_W-1:0] rand_operator();
      case ($urandom_range(0, 3))
         0:       return SYM_PLUS;
         1:       return SYM_MINUS;
         2:       return SYM_STAR;
         default: return SYM_SLASH;
      endcase
   endfunction

   // Half decimal digits, half arbitrary non-operator bytes.
   function automatic logic [SYM_W-1:0] rand_operand();
      logic [SYM_W-1:0] s;
      if ($urandom_range(0, 1) == 0) return SYM_ZERO + SYM_W'($urandom_range(0, 9));
      do s = SYM_W'($urandom_range(0, 255)); while (is_operator(s));
      return s;
   endfunction

   // Builds the most negative value as 128^4 * 8, pushes -1 and applies op.
   task automatic add_min_with_neg_one(input logic [SYM_W-1:0] op);
      add_char(8'd176, 1'b0);
      repeat (3) begin
         add_char(8'd176, 1'b0);
         add_char(SYM_STAR, 1'b0);
      end
      add_char("8", 1'b0);
      add_char(SYM_STAR, 1'b0);
      add_char("0", 1'b0);
      add_char("1", 1'b0);
      add_char(SYM_MINUS, 1'b0);
      add_char(op, 1'b1);
   endtask

   task automatic add_expression();
      int n_opnd;
      int depth;
      int used;
      logic [SYM_W-1:0] s;
      n_opnd = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      depth  = 0;
      used   = 0;
      while (used < n_opnd || depth > 1) begin
         if (used < n_opnd && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            s = rand_operand();
            depth++;
            used++;
         end else begin
            s = rand_operator();
            depth--;
         end
         add_char(s, used == n_opnd && depth == 1);
      end
   endtask

   // Broken sequences: operators and bytes in any order.
   task automatic add_noise();
      int len;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         add_char(($urandom_range(0, 1) == 0) ? rand_operator() : SYM_W'($urandom_range(0, 255)),
                  i == len - 1);
      end
   endtask

   // Fills the stack to just under, exactly at or beyond its depth.
   task automatic add_deep_push();
      int n;
      n = $urandom_range(DEPTH - 1, DEPTH + 6);
      for (int i = 0; i < n; i++) add_char(rand_operand(), i == n - 1);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   //---------------------------------------------------------------------------
   // Checking
   //---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_result();
      outcome_type o;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result value", rsp_if.value, '0);
      end else begin
         o = expected_results.pop_front();
         results_checked++;
         if (rsp_if.value !== o.value)
            report_mismatch("value", rsp_if.value, o.value);
         if (rsp_if.underflow !== o.underflow)
            report_mismatch("underflow", DATA_W'(rsp_if.underflow), DATA_W'(o.underflow));
         if (rsp_if.overflow !== o.overflow)
            report_mismatch("overflow", DATA_W'(rsp_if.overflow), DATA_W'(o.overflow));
         if (rsp_if.div_by_zero !== o.div_by_zero)
            report_mismatch("div_by_zero", DATA_W'(rsp_if.div_by_zero),
                            DATA_W'(o.div_by_zero));
      end
   endtask

   //---------------------------------------------------------------------------
   // Driver: predicts each accepted item, then offers the next one.
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            evaluate_symbol(req_if.symbol, req_if.last);
            chars_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               next_char     = pending_chars.pop_front();
               req_if.symbol <= next_char.symbol;
               req_if.last   <= next_char.last;
               req_if.valid  <= 1'b1;
               gap_left      <= hold_req ? 0 : pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Monitor: checks each accepted result and stalls at random.
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left   <= pick_gap();
         end
      end
   end

   // Long hold-off on the result side while characters keep coming.
   initial begin
      hold_req = 1'b0;
      wait (chars_sent >= 500);
      @(posedge clock);
      hold_req <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_req <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL postfix_expression_evaluator");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Main sequence
   //---------------------------------------------------------------------------
   initial begin
      int r;
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.symbol = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      stack_fill    = 0;
      sticky_under  = 1'b0;
      sticky_over   = 1'b0;
      sticky_div0   = 1'b0;
      error_count   = 0;
      chars_sent    = 0;
      results_checked = 0;
      under_results = 0;
      over_results  = 0;
      div0_results  = 0;
      cycle_count   = 0;

      // Directed: extreme codes, every operator, truncation of a negative
      // quotient, popping an empty stack, division by zero and the most
      // negative value divided by -1.
      add_char(8'hFF, 1'b1);
      add_char(8'h00, 1'b0);
      add_char("5", 1'b0);
      add_char(SYM_SLASH, 1'b1);
      add_char(SYM_PLUS, 1'b1);
      add_char("7", 1'b0);
      add_char("0", 1'b0);
      add_char(SYM_SLASH, 1'b1);
      add_char("9", 1'b0);
      add_char("4", 1'b0);
      add_char(SYM_MINUS, 1'b0);
      add_char("3", 1'b0);
      add_char(SYM_STAR, 1'b1);
      add_min_with_neg_one(SYM_SLASH);

      // Random: mostly well-formed expressions, some noise, a few deep
      // stacks and wrap cases.
      while (pending_chars.size() < NUM_CHARS) begin
         r = $urandom_range(0, 99);
         if (r < 75)      add_expression();
         else if (r < 95) add_noise();
         else if (r < 97) add_deep_push();
         else             add_min_with_neg_one(rand_operator());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_chars.size() == 0 && !req_if.valid);
      wait (expected_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d characters sent, %0d expression results checked", chars_sent,
               results_checked);
      $display("results with underflow %0d, overflow %0d, divide by zero %0d",
               under_results, over_results, div0_results);
      if (error_count == 0) begin
         $display("PASS postfix_expression_evaluator");
      end else begin
         $display("FAIL postfix_expression_evaluator");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/pee_pkg.sv
sv/pee_req_if.sv
sv/pee_rsp_if.sv
sv/pee_ram.sv
sv/pee_alu.sv
sv/postfix_expression_evaluator.sv
tb/sv/tb_postfix_expression_evaluator.sv
